// ----- sv/ptp_pkg.sv -----
// shared types and constants of the properties text parser
`timescale 1ns / 1ps
package ptp_pkg;

  localparam int unsigned QueueDepthDef = 4;

  localparam logic [7:0] ChrHash   = 8'h23;
  localparam logic [7:0] ChrBang   = 8'h21;
  localparam logic [7:0] ChrEq     = 8'h3D;
  localparam logic [7:0] ChrColon  = 8'h3A;
  localparam logic [7:0] ChrU      = 8'h75;
  localparam logic [7:0] ChrSpace  = 8'h20;
  localparam logic [7:0] ChrTab    = 8'h09;
  localparam logic [7:0] ChrLf     = 8'h0A;
  localparam logic [7:0] ChrCr     = 8'h0D;
  localparam logic [7:0] ChrBslash = 8'h5C;
  localparam logic [15:0] AsciiLimit = 16'd128;

  typedef enum logic [2:0] {
    KIND_KEY_BYTE   = 3'd0,
    KIND_KEY_END    = 3'd1,
    KIND_VALUE_BYTE = 3'd2,
    KIND_VALUE_END  = 3'd3,
    KIND_ERROR      = 3'd4,
    KIND_STREAM_END = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    ERR_EOF_KEY     = 3'd0,
    ERR_BREAK_KEY   = 3'd1,
    ERR_EOF_ESCAPE  = 3'd2,
    ERR_EOF_UNICODE = 3'd3,
    ERR_BAD_HEX     = 3'd4,
    ERR_NON_ASCII   = 3'd5
  } err_e;

  // classified input word
  typedef struct packed {
    logic [7:0] chr;
    logic       eof;
    logic       blank;
    logic       brk;
    logic       lf;
    logic       cr;
    logic       delim;
    logic       cmt;
    logic       bslash;
    logic       u_chr;
    logic       hex_ok;
    logic [3:0] hex_val;
  } tok_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] out_byte;
    logic [2:0] error_code;
    logic       final_res;
  } res_t;

endpackage

// ----- sv/ptp_in_if.sv -----
// input channel: raw text bytes and end marker
`timescale 1ns / 1ps
interface ptp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_marker;

  modport source (output valid, output in_byte, output end_marker, input ready);
  modport sink (input valid, input in_byte, input end_marker, output ready);
endinterface

// ----- sv/ptp_out_if.sv -----
// output channel: parse results
`timescale 1ns / 1ps
interface ptp_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] out_byte;
  logic [2:0] error_code;
  logic       final_res;

  modport source (output valid, output kind, output out_byte, output error_code,
                  output final_res, input ready);
  modport sink (input valid, input kind, input out_byte, input error_code,
                input final_res, output ready);
endinterface

// ----- sv/ptp_front.sv -----
// front stage: accepts input words and classifies each byte
`timescale 1ns / 1ps
module ptp_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  ptp_in_if.sink          in_i,
  output logic            tok_valid_o,
  output ptp_pkg::tok_t   tok_o,
  input  logic            tok_ready_i
);

  logic          valid_q, valid_d;
  ptp_pkg::tok_t tok_q;
  ptp_pkg::tok_t cls;
  logic          accept;
  logic [7:0]    c;

  assign in_i.ready  = !valid_q || tok_ready_i;
  assign accept      = in_i.valid && in_i.ready;
  assign tok_valid_o = valid_q;
  assign tok_o       = tok_q;
  assign c           = in_i.in_byte;

  always_comb begin
    cls         = '0;
    cls.chr     = c;
    cls.eof     = in_i.end_marker;
    cls.blank   = (c == ptp_pkg::ChrSpace) || (c == ptp_pkg::ChrTab);
    cls.lf      = (c == ptp_pkg::ChrLf);
    cls.cr      = (c == ptp_pkg::ChrCr);
    cls.brk     = cls.lf || cls.cr;
    cls.delim   = (c == ptp_pkg::ChrEq) || (c == ptp_pkg::ChrColon);
    cls.cmt     = (c == ptp_pkg::ChrHash) || (c == ptp_pkg::ChrBang);
    cls.bslash  = (c == ptp_pkg::ChrBslash);
    cls.u_chr   = (c == ptp_pkg::ChrU);
    if (c >= 8'h30 && c <= 8'h39) begin
      cls.hex_ok  = 1'b1;
      cls.hex_val = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      // letters a..f share low bits 1..6
      cls.hex_ok  = 1'b1;
      cls.hex_val = 4'd9 + c[3:0];
    end
  end

  always_comb begin
    if (accept) begin
      valid_d = 1'b1;
    end else if (tok_ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tok_q <= cls;
    end
  end

endmodule

// ----- sv/ptp_queue.sv -----
// short queue of classified words between front and back
`timescale 1ns / 1ps
module ptp_queue #(
  parameter int unsigned Depth = ptp_pkg::QueueDepthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ptp_pkg::tok_t push_tok_i,
  output logic          push_ready_o,
  output logic          pop_valid_o,
  output ptp_pkg::tok_t pop_tok_o,
  input  logic          pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  ptp_pkg::tok_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_tok_o    = mem_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_tok_i;
    end
  end

endmodule

// ----- sv/ptp_back.sv -----
// back stage: parse state machine and output register
`timescale 1ns / 1ps
module ptp_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          tok_valid_i,
  input  ptp_pkg::tok_t tok_i,
  output logic          tok_pop_o,
  ptp_out_if.source     out_o
);

  typedef enum logic [10:0] {
    S_BEFORE_KEY  = 11'b00000000001,
    S_COMMENT     = 11'b00000000010,
    S_KEY         = 11'b00000000100,
    S_KEY_SPACE   = 11'b00000001000,
    S_DELIM_SPACE = 11'b00000010000,
    S_VALUE       = 11'b00000100000,
    S_ESCAPE      = 11'b00001000000,
    S_UNICODE     = 11'b00010000000,
    S_CR_CONT     = 11'b00100000000,
    S_CONT_SPACE  = 11'b01000000000,
    S_DONE        = 11'b10000000000
  } mode_e;

  mode_e        mode_q, mode_d;
  logic         esc_key_q, esc_key_d;
  logic [15:0]  acc_q, acc_d;
  logic [2:0]   cnt_q, cnt_d;
  logic         res_v;
  ptp_pkg::res_t res;
  logic         out_valid_q, out_valid_d;
  ptp_pkg::res_t out_q;
  logic         pop;
  logic         go;
  logic [15:0]  acc_n;
  logic [2:0]   cnt_n;

  function automatic ptp_pkg::res_t mk(input ptp_pkg::kind_e k, input logic [7:0] b,
                                       input ptp_pkg::err_e e, input logic f);
    ptp_pkg::res_t r;
    r.kind       = k;
    r.out_byte   = b;
    r.error_code = e;
    r.final_res  = f;
    return r;
  endfunction

  assign pop       = tok_valid_i && (!out_valid_q || out_o.ready);
  assign tok_pop_o = pop;

  // pass-through modes chain into the next one within the same word
  always_comb begin
    mode_d    = mode_q;
    esc_key_d = esc_key_q;
    acc_d     = acc_q;
    cnt_d     = cnt_q;
    res_v     = 1'b0;
    res       = '0;
    go        = 1'b1;
    acc_n     = {acc_q[11:0], tok_i.hex_val};
    cnt_n     = cnt_q + 3'd1;
    for (int i = 0; i < 4; i++) begin
      if (go) begin
        case (mode_d)
          S_BEFORE_KEY: begin
            if (tok_i.eof) begin
              mode_d = S_DONE;
              res_v  = 1'b1;
              res    = mk(ptp_pkg::KIND_STREAM_END, '0, ptp_pkg::ERR_EOF_KEY, 1'b1);
              go     = 1'b0;
            end else if (tok_i.blank || tok_i.brk) begin
              go = 1'b0;
            end else if (tok_i.cmt) begin
              mode_d = S_COMMENT;
              go     = 1'b0;
            end else begin
              mode_d = S_KEY;
            end
          end
          S_COMMENT: begin
            if (tok_i.eof) begin
              mode_d = S_DONE;
              res_v  = 1'b1;
              res    = mk(ptp_pkg::KIND_STREAM_END, '0, ptp_pkg::ERR_EOF_KEY, 1'b1);
            end else if (tok_i.brk) begin
              mode_d = S_BEFORE_KEY;
            end
            go = 1'b0;
          end
          S_KEY: begin
            res_v = 1'b1;
            if (tok_i.eof) begin
              mode_d = S_DONE;
              res    = mk(ptp_pkg::KIND_ERROR, '0, ptp_pkg::ERR_EOF_KEY, 1'b1);
            end else if (tok_i.bslash) begin
              res_v     = 1'b0;
              esc_key_d = 1'b1;
              mode_d    = S_ESCAPE;
            end else if (tok_i.brk) begin
              mode_d = S_DONE;
              res    = mk(ptp_pkg::KIND_ERROR, '0, ptp_pkg::ERR_BREAK_KEY, 1'b1);
            end else if (tok_i.delim) begin
              mode_d = S_DELIM_SPACE;
              res    = mk(ptp_pkg::KIND_KEY_END, '0, ptp_pkg::ERR_EOF_KEY, 1'b0);
            end else if (tok_i.blank) begin
              mode_d = S_KEY_SPACE;
              res    = mk(ptp_pkg::KIND_KEY_END, '0, ptp_pkg::ERR_EOF_KEY, 1'b0);
            end else begin
              res = mk(ptp_pkg::KIND_KEY_BYTE, tok_i.chr, ptp_pkg::ERR_EOF_KEY, 1'b0);
            end
            go = 1'b0;
          end
          S_KEY_SPACE: begin
            if (!tok_i.eof && tok_i.blank) begin
              go = 1'b0;
            end else if (!tok_i.eof && tok_i.delim) begin
              mode_d = S_DELIM_SPACE;
              go     = 1'b0;
            end else begin
              mode_d = S_VALUE;
            end
          end
          S_DELIM_SPACE: begin
            if (!tok_i.eof && tok_i.blank) begin
              go = 1'b0;
            end else begin
              mode_d = S_VALUE;
            end
          end
          S_VALUE: begin
            res_v = 1'b1;
            if (tok_i.eof) begin
              mode_d = S_DONE;
              res    = mk(ptp_pkg::KIND_VALUE_END, '0, ptp_pkg::ERR_EOF_KEY, 1'b1);
            end else if (tok_i.brk) begin
              mode_d = S_BEFORE_KEY;
              res    = mk(ptp_pkg::KIND_VALUE_END, '0, ptp_pkg::ERR_EOF_KEY, 1'b0);
            end else if (tok_i.bslash) begin
              res_v     = 1'b0;
              esc_key_d = 1'b0;
              mode_d    = S_ESCAPE;
            end else begin
              res = mk(ptp_pkg::KIND_VALUE_BYTE, tok_i.chr, ptp_pkg::ERR_EOF_KEY, 1'b0);
            end
            go = 1'b0;
          end
          S_ESCAPE: begin
            if (tok_i.eof) begin
              mode_d = S_DONE;
              res_v  = 1'b1;
              res    = mk(ptp_pkg::KIND_ERROR, '0, ptp_pkg::ERR_EOF_ESCAPE, 1'b1);
            end else if (tok_i.u_chr) begin
              acc_d  = '0;
              cnt_d  = '0;
              mode_d = S_UNICODE;
            end else if (tok_i.lf) begin
              mode_d = S_CONT_SPACE;
            end else if (tok_i.cr) begin
              mode_d = S_CR_CONT;
            end else begin
              mode_d = esc_key_d ? S_KEY : S_VALUE;
              res_v  = 1'b1;
              res    = mk(esc_key_d ? ptp_pkg::KIND_KEY_BYTE : ptp_pkg::KIND_VALUE_BYTE,
                          tok_i.chr, ptp_pkg::ERR_EOF_KEY, 1'b0);
            end
            go = 1'b0;
          end
          S_UNICODE: begin
            if (tok_i.eof) begin
              mode_d = S_DONE;
              res_v  = 1'b1;
              res    = mk(ptp_pkg::KIND_ERROR, '0, ptp_pkg::ERR_EOF_UNICODE, 1'b1);
            end else if (!tok_i.hex_ok) begin
              mode_d = S_DONE;
              res_v  = 1'b1;
              res    = mk(ptp_pkg::KIND_ERROR, '0, ptp_pkg::ERR_BAD_HEX, 1'b1);
            end else begin
              acc_d = acc_n;
              cnt_d = cnt_n;
              if (cnt_n >= 3'd4) begin
                cnt_d = '0;
                res_v = 1'b1;
                if (acc_n >= ptp_pkg::AsciiLimit) begin
                  mode_d = S_DONE;
                  res    = mk(ptp_pkg::KIND_ERROR, '0, ptp_pkg::ERR_NON_ASCII, 1'b1);
                end else begin
                  mode_d = esc_key_d ? S_KEY : S_VALUE;
                  res    = mk(esc_key_d ? ptp_pkg::KIND_KEY_BYTE
                                        : ptp_pkg::KIND_VALUE_BYTE,
                              acc_n[7:0], ptp_pkg::ERR_EOF_KEY, 1'b0);
                end
              end
            end
            go = 1'b0;
          end
          S_CR_CONT: begin
            mode_d = S_CONT_SPACE;
            if (!tok_i.eof && tok_i.lf) begin
              go = 1'b0;
            end
          end
          S_CONT_SPACE: begin
            if (!tok_i.eof && tok_i.blank) begin
              go = 1'b0;
            end else begin
              mode_d = esc_key_d ? S_KEY : S_VALUE;
            end
          end
          default: begin
            go = 1'b0;
          end
        endcase
      end
    end
  end

  always_comb begin
    if (pop && res_v) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= S_BEFORE_KEY;
      esc_key_q   <= 1'b0;
      acc_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop) begin
        mode_q    <= mode_d;
        esc_key_q <= esc_key_d;
        acc_q     <= acc_d;
        cnt_q     <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && res_v) begin
      out_q <= res;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.kind       = out_q.kind;
  assign out_o.out_byte   = out_q.out_byte;
  assign out_o.error_code = out_q.error_code;
  assign out_o.final_res  = out_q.final_res;

endmodule

// ----- sv/properties_text_parser.sv -----
// top level of the properties text parser
//
// in_i carries one text byte per word, or an end marker with no byte.
// out_o carries at most one result per input word: key bytes, key end,
// value bytes, value end, an error or the stream end; final_res marks the
// last result of the stream, after which input words are taken and dropped
// until reset.
// Throughput is one input word per cycle while the receiver takes results;
// the parse state machine in the back stage resolves each word, including
// chained whitespace and line continuation steps, combinationally.
// A word passes through the classify register of the front, a queue slot
// and the output register of the back stage, in that order, and may wait
// at any of them while the receiver stalls.
// The queue (QueueDepth words) lets the front keep accepting while the back
// waits on a stalled receiver; once the queue and the front register fill
// behind a held output register, in_i ready drops. A result held in the
// output register stays until taken.
// Reset clears the parse mode to "before key", the queue and all valid
// flags; no clearing pass is needed.
`timescale 1ns / 1ps
module properties_text_parser #(
  parameter int unsigned QueueDepth = ptp_pkg::QueueDepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ptp_in_if.sink    in_i,
  ptp_out_if.source out_o
);

  logic          f_valid, f_ready;
  ptp_pkg::tok_t f_tok;
  logic          q_valid, q_pop;
  ptp_pkg::tok_t q_tok;

  ptp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .tok_valid_o (f_valid),
    .tok_o       (f_tok),
    .tok_ready_i (f_ready)
  );

  ptp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (f_valid),
    .push_tok_i   (f_tok),
    .push_ready_o (f_ready),
    .pop_valid_o  (q_valid),
    .pop_tok_o    (q_tok),
    .pop_i        (q_pop)
  );

  ptp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (q_valid),
    .tok_i       (q_tok),
    .tok_pop_o   (q_pop),
    .out_o       (out_o)
  );

endmodule

// ----- tb/testbench.sv -----
// self-checking testbench for the properties text parser, one text stream per run
`timescale 1ns / 1ps
module testbench;
  import ptp_pkg::*;

  localparam int          RandWords  = 930;
  localparam int          HoldAfter  = 300;
  localparam int          HoldCycles = 80;
  localparam int          CycleLimit = 200000;
  localparam logic [2:0]  NoErr      = 3'd0;

  typedef enum logic [3:0] {
    PM_BEFORE_KEY, PM_COMMENT, PM_KEY, PM_KEY_SPACE, PM_DELIM_SPACE, PM_VALUE,
    PM_ESCAPE, PM_UNICODE, PM_CR_CONT, PM_CONT_SPACE, PM_DONE
  } pmode_e;

  typedef struct packed {
    pmode_e      mode;
    logic        esc_key;
    logic [15:0] hex_acc;
    logic [2:0]  hex_cnt;
  } parse_st_t;

  typedef struct packed {
    logic [7:0] chr;
    logic       eof;
    logic       typed;
    res_t       want;
  } text_row_t;

  typedef enum int {
    END_EOF_IDLE, END_EOF_COMMENT, END_EOF_KEY, END_BREAK_KEY, END_EOF_ESCAPE,
    END_EOF_UNICODE, END_BAD_HEX, END_NON_ASCII, END_EOF_VALUE, END_EOF_EMPTY_VALUE,
    END_EOF_KEY_SPACE
  } ending_e;

  logic clk_i;
  logic rst_ni;

  ptp_in_if  in_if ();
  ptp_out_if out_if ();

  properties_text_parser u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  parse_st_t parse_st = '{PM_BEFORE_KEY, 1'b0, 16'h0000, 3'd0};
  res_t      parsed_tokens[$];
  text_row_t script_q[$];
  ending_e   ending;
  int        burst_left;
  int        n_words;
  int        n_directed;
  int        n_checked;
  int        n_entries;
  int        n_fail;
  int        cycles;
  int        rx_cyc;
  int        hold_left;
  bit        hold_req;
  bit        hold_done;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic res_t word_res(input logic [2:0] k, input logic [7:0] b,
                                    input logic [2:0] e, input logic fin);
    res_t r;
    r.kind       = k;
    r.out_byte   = b;
    r.error_code = e;
    r.final_res  = fin;
    return r;
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == ChrSpace || c == ChrTab;
  endfunction

  function automatic bit is_break(input logic [7:0] c);
    return c == ChrCr || c == ChrLf;
  endfunction

  function automatic bit is_delim(input logic [7:0] c);
    return c == ChrEq || c == ChrColon;
  endfunction

  // one word through the parser; returns 1 when it yields a result
  function automatic bit parse_word(inout parse_st_t st, input logic [7:0] c,
                                    input logic eof, output res_t r);
    bit again;
    bit hit;
    logic [3:0] d;
    bit hex_ok;
    hit   = 1'b0;
    r     = '0;
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      case (st.mode)
        PM_BEFORE_KEY: begin
          if (eof) begin
            st.mode = PM_DONE;
            hit = 1'b1;
            r = word_res(KIND_STREAM_END, 8'h00, NoErr, 1'b1);
          end else if (c == ChrHash || c == ChrBang) begin
            st.mode = PM_COMMENT;
          end else if (!is_blank(c) && !is_break(c)) begin
            st.mode = PM_KEY;
            again = 1'b1;
          end
        end
        PM_COMMENT: begin
          if (eof) begin
            st.mode = PM_DONE;
            hit = 1'b1;
            r = word_res(KIND_STREAM_END, 8'h00, NoErr, 1'b1);
          end else if (is_break(c)) begin
            st.mode = PM_BEFORE_KEY;
          end
        end
        PM_KEY: begin
          if (eof) begin
            st.mode = PM_DONE;
            hit = 1'b1;
            r = word_res(KIND_ERROR, 8'h00, ERR_EOF_KEY, 1'b1);
          end else if (c == ChrBslash) begin
            st.esc_key = 1'b1;
            st.mode = PM_ESCAPE;
          end else if (is_break(c)) begin
            st.mode = PM_DONE;
            hit = 1'b1;
            r = word_res(KIND_ERROR, 8'h00, ERR_BREAK_KEY, 1'b1);
          end else if (is_delim(c) || is_blank(c)) begin
            st.mode = is_delim(c) ? PM_DELIM_SPACE : PM_KEY_SPACE;
            hit = 1'b1;
            r = word_res(KIND_KEY_END, 8'h00, NoErr, 1'b0);
          end else begin
            hit = 1'b1;
            r = word_res(KIND_KEY_BYTE, c, NoErr, 1'b0);
          end
        end
        PM_KEY_SPACE: begin
          if (!eof && is_delim(c)) begin
            st.mode = PM_DELIM_SPACE;
          end else if (eof || !is_blank(c)) begin
            st.mode = PM_VALUE;
            again = 1'b1;
          end
        end
        PM_DELIM_SPACE: begin
          if (eof || !is_blank(c)) begin
            st.mode = PM_VALUE;
            again = 1'b1;
          end
        end
        PM_VALUE: begin
          if (eof) begin
            st.mode = PM_DONE;
            hit = 1'b1;
            r = word_res(KIND_VALUE_END, 8'h00, NoErr, 1'b1);
          end else if (is_break(c)) begin
            st.mode = PM_BEFORE_KEY;
            hit = 1'b1;
            r = word_res(KIND_VALUE_END, 8'h00, NoErr, 1'b0);
          end else if (c == ChrBslash) begin
            st.esc_key = 1'b0;
            st.mode = PM_ESCAPE;
          end else begin
            hit = 1'b1;
            r = word_res(KIND_VALUE_BYTE, c, NoErr, 1'b0);
          end
        end
        PM_ESCAPE: begin
          if (eof) begin
            st.mode = PM_DONE;
            hit = 1'b1;
            r = word_res(KIND_ERROR, 8'h00, ERR_EOF_ESCAPE, 1'b1);
          end else if (c == ChrU) begin
            st.hex_acc = 16'h0000;
            st.hex_cnt = 3'd0;
            st.mode = PM_UNICODE;
          end else if (c == ChrLf) begin
            st.mode = PM_CONT_SPACE;
          end else if (c == ChrCr) begin
            st.mode = PM_CR_CONT;
          end else begin
            hit = 1'b1;
            if (st.esc_key) begin
              st.mode = PM_KEY;
              r = word_res(KIND_KEY_BYTE, c, NoErr, 1'b0);
            end else begin
              st.mode = PM_VALUE;
              r = word_res(KIND_VALUE_BYTE, c, NoErr, 1'b0);
            end
          end
        end
        PM_UNICODE: begin
          hex_ok = 1'b1;
          d = 4'h0;
          if (c >= "0" && c <= "9") d = 4'(c - "0");
          else if (c >= "A" && c <= "F") d = 4'(c - "A" + 8'd10);
          else if (c >= "a" && c <= "f") d = 4'(c - "a" + 8'd10);
          else hex_ok = 1'b0;
          if (eof) begin
            st.mode = PM_DONE;
            hit = 1'b1;
            r = word_res(KIND_ERROR, 8'h00, ERR_EOF_UNICODE, 1'b1);
          end else if (!hex_ok) begin
            st.mode = PM_DONE;
            hit = 1'b1;
            r = word_res(KIND_ERROR, 8'h00, ERR_BAD_HEX, 1'b1);
          end else begin
            st.hex_acc = {st.hex_acc[11:0], d};
            st.hex_cnt = st.hex_cnt + 3'd1;
            if (st.hex_cnt >= 3'd4) begin
              st.hex_cnt = 3'd0;
              hit = 1'b1;
              // range is checked only once all four digits are in
              if (st.hex_acc >= AsciiLimit) begin
                st.mode = PM_DONE;
                r = word_res(KIND_ERROR, 8'h00, ERR_NON_ASCII, 1'b1);
              end else if (st.esc_key) begin
                st.mode = PM_KEY;
                r = word_res(KIND_KEY_BYTE, st.hex_acc[7:0], NoErr, 1'b0);
              end else begin
                st.mode = PM_VALUE;
                r = word_res(KIND_VALUE_BYTE, st.hex_acc[7:0], NoErr, 1'b0);
              end
            end
          end
        end
        PM_CR_CONT: begin
          st.mode = PM_CONT_SPACE;
          if (eof || c != ChrLf) again = 1'b1;
        end
        PM_CONT_SPACE: begin
          if (eof || !is_blank(c)) begin
            st.mode = st.esc_key ? PM_KEY : PM_VALUE;
            again = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    return hit;
  endfunction

  // a byte is safe when it neither closes the stream nor starts a unicode escape
  // that can only end out of range
  function automatic bit keeps_open(input parse_st_t st, input logic [7:0] c);
    res_t r;
    bit hit;
    logic [31:0] reach;
    hit = parse_word(st, c, 1'b0, r);
    if (hit && r.final_res) return 1'b0;
    reach = 32'(st.hex_acc) << (4 * (4 - int'(st.hex_cnt)));
    return !(st.mode == PM_UNICODE && reach >= 32'(AsciiLimit));
  endfunction

  task automatic add_row(input logic [7:0] c, input logic eof, input logic typed,
                         input res_t want);
    text_row_t r;
    r.chr   = c;
    r.eof   = eof;
    r.typed = typed;
    r.want  = want;
    script_q = {script_q, r};
  endtask

  task automatic send_row(input text_row_t r);
    res_t tok;
    bit hit;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_if.valid      <= 1'b1;
    in_if.in_byte    <= r.chr;
    in_if.end_marker <= r.eof;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    burst_left--;
    n_words++;
    if (n_words == HoldAfter) hold_req <= 1'b1;
    hit = parse_word(parse_st, r.chr, r.eof, tok);
    // hand-written rows carry their own result
    if (r.typed) begin
      hit = 1'b1;
      tok = r.want;
    end
    if (hit) parsed_tokens = {parsed_tokens, tok};
  endtask

  task automatic send_chr(input logic [7:0] c);
    text_row_t r;
    r.chr   = c;
    r.eof   = 1'b0;
    r.typed = 1'b0;
    r.want  = '0;
    send_row(r);
  endtask

  function automatic logic [7:0] pick_blank();
    return ($urandom_range(0, 1) == 0) ? ChrSpace : ChrTab;
  endfunction

  function automatic logic [7:0] hex_chr(input logic [3:0] v);
    if (v < 4'd10) return 8'("0" + v);
    return 8'((($urandom_range(0, 1) == 0) ? "A" : "a") + v - 4'd10);
  endfunction

  function automatic logic [7:0] key_chr(input bit first);
    logic [7:0] c;
    do c = 8'($urandom);
    while (is_blank(c) || is_break(c) || is_delim(c) || c == ChrBslash ||
           (first && (c == ChrHash || c == ChrBang)));
    return c;
  endfunction

  function automatic logic [7:0] value_chr();
    logic [7:0] c;
    do c = 8'($urandom);
    while (is_break(c) || c == ChrBslash);
    return c;
  endfunction

  // mostly special characters so the noise lands on the parser's decisions
  function automatic logic [7:0] noise_chr();
    case ($urandom_range(0, 11))
      0: return ChrSpace;
      1: return ChrTab;
      2: return ChrCr;
      3: return ChrLf;
      4: return ChrBslash;
      5: return ChrU;
      6: return ChrEq;
      7: return ChrColon;
      8: return ($urandom_range(0, 1) == 0) ? ChrHash : ChrBang;
      9: return hex_chr(4'($urandom));
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_break();
    case ($urandom_range(0, 2))
      0: send_chr(ChrLf);
      1: send_chr(ChrCr);
      default: begin
        send_chr(ChrCr);
        send_chr(ChrLf);
      end
    endcase
  endtask

  task automatic send_escape(output bit cont);
    logic [7:0] c;
    cont = 1'b0;
    send_chr(ChrBslash);
    case ($urandom_range(0, 3))
      0: begin
        // unicode escape that stays below 128
        send_chr(ChrU);
        send_chr("0");
        send_chr("0");
        send_chr(hex_chr(4'($urandom_range(0, 7))));
        send_chr(hex_chr(4'($urandom)));
      end
      1: begin
        cont = 1'b1;
        send_break();
        repeat ($urandom_range(0, 3)) send_chr(pick_blank());
      end
      default: begin
        do c = 8'($urandom);
        while (c == ChrU || is_break(c));
        send_chr(c);
      end
    endcase
  endtask

  task automatic send_entry();
    int n;
    bit cont;
    bit unused;
    case ($urandom_range(0, 9))
      0: begin
        repeat ($urandom_range(0, 3)) send_chr(pick_blank());
        send_break();
      end
      1: begin
        repeat ($urandom_range(0, 2)) send_chr(pick_blank());
        send_chr(($urandom_range(0, 1) == 0) ? ChrHash : ChrBang);
        repeat ($urandom_range(0, 8)) send_chr(value_chr());
        send_break();
      end
      default: begin
        repeat ($urandom_range(0, 2)) send_chr(pick_blank());
        cont = 1'b0;
        n = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 4) == 0) begin
            send_escape(cont);
          end else begin
            send_chr(key_chr(i == 0));
            cont = 1'b0;
          end
        end
        // blanks alone end a key unless a continuation would swallow them
        if (n > 0 && !cont && $urandom_range(0, 2) == 0) begin
          repeat ($urandom_range(1, 2)) send_chr(pick_blank());
        end else begin
          repeat ($urandom_range(0, 2)) send_chr(pick_blank());
          send_chr(($urandom_range(0, 1) == 0) ? ChrEq : ChrColon);
          repeat ($urandom_range(0, 2)) send_chr(pick_blank());
        end
        repeat ($urandom_range(0, 8)) begin
          if ($urandom_range(0, 4) == 0) send_escape(unused);
          else send_chr(value_chr());
        end
        send_break();
      end
    endcase
  endtask

  // bring the parser back to a line start without closing the stream
  task automatic settle_line();
    while (parse_st.mode != PM_BEFORE_KEY) begin
      if (keeps_open(parse_st, ChrLf)) send_chr(ChrLf);
      else if (keeps_open(parse_st, ChrEq)) send_chr(ChrEq);
      else send_chr("0");
    end
  endtask

  task automatic send_noise();
    logic [7:0] c;
    repeat ($urandom_range(1, 8)) begin
      do c = noise_chr();
      while (!keeps_open(parse_st, c));
      send_chr(c);
    end
    // noise can stop mid key or mid escape, where the next entry could close the stream
    settle_line();
  endtask

  task automatic build_ending();
    case (ending)
      END_EOF_IDLE: begin
        add_row(8'($urandom), 1'b1, 1'b1, word_res(KIND_STREAM_END, 8'h00, NoErr, 1'b1));
      end
      END_EOF_COMMENT: begin
        add_row(ChrHash, 1'b0, 1'b0, '0);
        add_row("x", 1'b0, 1'b0, '0);
        add_row(8'($urandom), 1'b1, 1'b1, word_res(KIND_STREAM_END, 8'h00, NoErr, 1'b1));
      end
      END_EOF_KEY: begin
        add_row("k", 1'b0, 1'b0, '0);
        add_row(8'($urandom), 1'b1, 1'b1, word_res(KIND_ERROR, 8'h00, ERR_EOF_KEY, 1'b1));
      end
      END_BREAK_KEY: begin
        add_row("k", 1'b0, 1'b0, '0);
        add_row(ChrLf, 1'b0, 1'b1, word_res(KIND_ERROR, 8'h00, ERR_BREAK_KEY, 1'b1));
      end
      END_EOF_ESCAPE: begin
        add_row("k", 1'b0, 1'b0, '0);
        add_row(ChrBslash, 1'b0, 1'b0, '0);
        add_row(8'($urandom), 1'b1, 1'b1,
                word_res(KIND_ERROR, 8'h00, ERR_EOF_ESCAPE, 1'b1));
      end
      END_EOF_UNICODE: begin
        add_row("k", 1'b0, 1'b0, '0);
        add_row(ChrEq, 1'b0, 1'b0, '0);
        add_row(ChrBslash, 1'b0, 1'b0, '0);
        add_row(ChrU, 1'b0, 1'b0, '0);
        add_row("0", 1'b0, 1'b0, '0);
        add_row(8'($urandom), 1'b1, 1'b1,
                word_res(KIND_ERROR, 8'h00, ERR_EOF_UNICODE, 1'b1));
      end
      END_BAD_HEX: begin
        add_row("k", 1'b0, 1'b0, '0);
        add_row(ChrEq, 1'b0, 1'b0, '0);
        add_row(ChrBslash, 1'b0, 1'b0, '0);
        add_row(ChrU, 1'b0, 1'b0, '0);
        add_row("g", 1'b0, 1'b1, word_res(KIND_ERROR, 8'h00, ERR_BAD_HEX, 1'b1));
      end
      END_NON_ASCII: begin
        add_row("k", 1'b0, 1'b0, '0);
        add_row(ChrBslash, 1'b0, 1'b0, '0);
        add_row(ChrU, 1'b0, 1'b0, '0);
        add_row("0", 1'b0, 1'b0, '0);
        add_row("0", 1'b0, 1'b0, '0);
        add_row("8", 1'b0, 1'b0, '0);
        add_row("0", 1'b0, 1'b1, word_res(KIND_ERROR, 8'h00, ERR_NON_ASCII, 1'b1));
      end
      END_EOF_VALUE: begin
        add_row("k", 1'b0, 1'b0, '0);
        add_row(ChrEq, 1'b0, 1'b0, '0);
        add_row("v", 1'b0, 1'b0, '0);
        add_row(8'($urandom), 1'b1, 1'b1, word_res(KIND_VALUE_END, 8'h00, NoErr, 1'b1));
      end
      END_EOF_EMPTY_VALUE: begin
        add_row("k", 1'b0, 1'b0, '0);
        add_row(ChrColon, 1'b0, 1'b0, '0);
        add_row(8'($urandom), 1'b1, 1'b1, word_res(KIND_VALUE_END, 8'h00, NoErr, 1'b1));
      end
      default: begin
        add_row("k", 1'b0, 1'b0, '0);
        add_row(ChrSpace, 1'b0, 1'b0, '0);
        add_row(8'($urandom), 1'b1, 1'b1, word_res(KIND_VALUE_END, 8'h00, NoErr, 1'b1));
      end
    endcase
    // anything after the last result is dropped
    repeat ($urandom_range(3, 6)) add_row(8'($urandom), 1'($urandom), 1'b0, '0);
  endtask

  initial begin
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.in_byte    = 8'h00;
    in_if.end_marker = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed text: comment, empty key, line break after the delimiter, byte extremes,
    // escaped delimiter, blank then colon, unicode escape, CRLF continuation
    add_row(ChrSpace, 1'b0, 1'b0, '0);
    add_row(ChrBang, 1'b0, 1'b0, '0);
    add_row(8'h80, 1'b0, 1'b0, '0);
    add_row(ChrLf, 1'b0, 1'b0, '0);
    add_row(ChrEq, 1'b0, 1'b1, word_res(KIND_KEY_END, 8'h00, NoErr, 1'b0));
    add_row(ChrCr, 1'b0, 1'b1, word_res(KIND_VALUE_END, 8'h00, NoErr, 1'b0));
    add_row(ChrLf, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b1, word_res(KIND_KEY_BYTE, 8'h00, NoErr, 1'b0));
    add_row(8'hFF, 1'b0, 1'b1, word_res(KIND_KEY_BYTE, 8'hFF, NoErr, 1'b0));
    add_row(ChrBslash, 1'b0, 1'b0, '0);
    add_row(ChrEq, 1'b0, 1'b1, word_res(KIND_KEY_BYTE, ChrEq, NoErr, 1'b0));
    add_row(ChrSpace, 1'b0, 1'b1, word_res(KIND_KEY_END, 8'h00, NoErr, 1'b0));
    add_row(ChrColon, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b0, 1'b1, word_res(KIND_VALUE_BYTE, 8'hFF, NoErr, 1'b0));
    add_row(ChrBslash, 1'b0, 1'b0, '0);
    add_row(ChrU, 1'b0, 1'b0, '0);
    add_row("0", 1'b0, 1'b0, '0);
    add_row("0", 1'b0, 1'b0, '0);
    add_row("7", 1'b0, 1'b0, '0);
    add_row("F", 1'b0, 1'b1, word_res(KIND_VALUE_BYTE, 8'h7F, NoErr, 1'b0));
    add_row(ChrBslash, 1'b0, 1'b0, '0);
    add_row(ChrCr, 1'b0, 1'b0, '0);
    add_row(ChrLf, 1'b0, 1'b0, '0);
    add_row(ChrTab, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b1, word_res(KIND_VALUE_BYTE, 8'h00, NoErr, 1'b0));
    add_row(ChrLf, 1'b0, 1'b1, word_res(KIND_VALUE_END, 8'h00, NoErr, 1'b0));
    while (script_q.size() != 0) send_row(script_q.pop_front());
    n_directed = n_words;

    while (n_words - n_directed < RandWords) begin
      if ($urandom_range(0, 7) == 0) send_noise();
      else send_entry();
    end

    settle_line();

    ending = ending_e'($urandom_range(0, int'(END_EOF_KEY_SPACE)));
    build_ending();
    while (script_q.size() != 0) send_row(script_q.pop_front());
    in_if.valid <= 1'b0;

    while (parsed_tokens.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("%0d input words (%0d directed), %0d results checked over %0d entries",
             n_words, n_directed, n_checked, n_entries);
    $display("stream closed by %s", ending.name());
    if (n_fail == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // result check and receiver stall pattern
  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = word_res(out_if.kind, out_if.out_byte, out_if.error_code, out_if.final_res);
      n_checked++;
      if (got.kind == KIND_VALUE_END) n_entries++;
      if (parsed_tokens.size() == 0) begin
        $display("%0t unexpected result: expected none, actual kind %0d byte %h err %0d fin %0b",
                 $time, got.kind, got.out_byte, got.error_code, got.final_res);
        n_fail++;
      end else begin
        want = parsed_tokens.pop_front();
        if (got.kind != want.kind) begin
          $display("%0t kind: expected %0d actual %0d", $time, want.kind, got.kind);
          n_fail++;
        end
        if (got.out_byte != want.out_byte) begin
          $display("%0t out_byte: expected %h actual %h", $time, want.out_byte, got.out_byte);
          n_fail++;
        end
        if (got.error_code != want.error_code) begin
          $display("%0t error_code: expected %0d actual %0d", $time, want.error_code,
                   got.error_code);
          n_fail++;
        end
        if (got.final_res != want.final_res) begin
          $display("%0t final_res: expected %0b actual %0b", $time, want.final_res,
                   got.final_res);
          n_fail++;
        end
      end
    end

    rx_cyc++;
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      // long hold-off so the queue fills and input ready drops
      hold_done = 1'b1;
      hold_left = HoldCycles - 1;
      out_if.ready <= 1'b0;
    end else begin
      case (rx_cyc[9:8])
        2'd0: out_if.ready <= 1'b1;
        2'd1: out_if.ready <= (rx_cyc[1:0] != 2'd3);
        2'd2: out_if.ready <= ($urandom_range(0, 9) >= 4);
        default: out_if.ready <= rx_cyc[4];
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("%0t timeout with %0d results outstanding", $time, parsed_tokens.size());
      $display("Mismatches found");
      $finish;
    end
  end

endmodule
